/* src/dnsr_pkg.sv */
// ----------------------------------------------------------------------------
// dnsr_pkg
// Shared types, constants and byte tables of the captive DNS responder.
// ----------------------------------------------------------------------------
package dnsr_pkg;

    localparam int HDR_LEN = 12;
    localparam int ANS_LEN = 16;

    localparam logic [15:0] RESP_FLAGS = 16'h8180;
    localparam logic [7:0]  NAME_PTR   = 8'hC0;
    localparam logic [7:0]  TTL_SEC    = 8'h3C;
    localparam logic [7:0]  TAIL_LEN   = 8'd4;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_LABLEN,
        PH_LABEL,
        PH_TAIL,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        FIN_NONE,
        FIN_DISCARD,
        FIN_ANSWER
    } fin_t;

    // what one accepted query byte leaves for the output side
    typedef struct packed {
        logic       emit;
        logic [7:0] data;
        fin_t       fin;
    } parse_res_t;

    function automatic logic [7:0] hdr_byte(input logic [3:0] pos, input logic [7:0] b);
        logic [7:0] r;
        case (pos)
            4'd0, 4'd1: r = b;
            4'd2:       r = RESP_FLAGS[15:8];
            4'd3:       r = RESP_FLAGS[7:0];
            4'd5, 4'd7: r = 8'h01;
            default:    r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] ans_byte(input logic [3:0] idx, input logic [31:0] ip);
        logic [7:0] r;
        case (idx)
            4'd0:         r = NAME_PTR;
            4'd1:         r = 8'(HDR_LEN);
            4'd3, 4'd5:   r = 8'h01;
            4'd9:         r = TTL_SEC;
            4'd11:        r = 8'h04;
            4'd12:        r = ip[31:24];
            4'd13:        r = ip[23:16];
            4'd14:        r = ip[15:8];
            4'd15:        r = ip[7:0];
            default:      r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

/* src/dnsr_parser.sv */
// ----------------------------------------------------------------------------
// dnsr_parser
// Tracks header, question labels and type/class of the incoming query and
// decides per byte what is copied and how the packet ends.
// ----------------------------------------------------------------------------
module dnsr_parser
    import dnsr_pkg::*;
#(
    parameter int MAX_PACKET = 512
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_accept,
    input  logic [7:0] in_data,
    input  logic       in_last,
    output parse_res_t res
);

    localparam int POS_W = $clog2(MAX_PACKET + 1);

    logic [POS_W-1:0] pos_reg, pos_next;
    phase_t           phase_reg, phase_next, phase_adv;
    logic [7:0]       skip_reg, skip_next, skip_adv;
    logic             in_range;
    logic [7:0]       skip_dec;

    assign in_range = pos_reg < POS_W'(MAX_PACKET);
    assign skip_dec = skip_reg - 8'd1;

    // next state
    always_comb
    begin
        phase_adv = phase_reg;
        skip_adv  = skip_reg;
        if (in_range)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (pos_reg == POS_W'(HDR_LEN - 1))
                        phase_adv = PH_LABLEN;
                end
                PH_LABLEN:
                begin
                    if (in_data == 8'd0)
                    begin
                        phase_adv = PH_TAIL;
                        skip_adv  = TAIL_LEN;
                    end
                    else
                    begin
                        phase_adv = PH_LABEL;
                        skip_adv  = in_data;
                    end
                end
                PH_LABEL:
                begin
                    skip_adv = skip_dec;
                    if (skip_dec == 8'd0)
                        phase_adv = PH_LABLEN;
                end
                PH_TAIL:
                begin
                    skip_adv = skip_dec;
                    if (skip_dec == 8'd0)
                        phase_adv = PH_DONE;
                end
                default: ;
            endcase
        end

        if (in_last)
        begin
            phase_next = PH_HEADER;
            skip_next  = 8'd0;
            pos_next   = '0;
        end
        else
        begin
            phase_next = phase_adv;
            skip_next  = skip_adv;
            pos_next   = in_range ? pos_reg + POS_W'(1) : pos_reg;
        end
    end

    // outputs
    always_comb
    begin
        res.emit = in_range && (phase_reg != PH_DONE);
        case (phase_reg)
            PH_HEADER: res.data = hdr_byte(pos_reg[3:0], in_data);
            default:   res.data = in_data;
        endcase
        if (!in_last)
            res.fin = FIN_NONE;
        else if (phase_adv == PH_DONE)
            res.fin = FIN_ANSWER;
        else
            res.fin = FIN_DISCARD;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            phase_reg <= PH_HEADER;
            skip_reg  <= 8'd0;
        end
        else if (in_accept)
        begin
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            skip_reg  <= skip_next;
        end
    end

endmodule

/* src/dnsr_emitter.sv */
// ----------------------------------------------------------------------------
// dnsr_emitter
// Holds the words of one parsed byte, plays out the answer record and
// drives the registered output word.
// ----------------------------------------------------------------------------
module dnsr_emitter
    import dnsr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  parse_res_t  res,
    input  logic [31:0] ip,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        out_last,
    output logic        out_disc
);

    logic       pend_emit_reg;
    logic [7:0] pend_data_reg;
    fin_t       pend_fin_reg;
    logic [3:0] ans_idx_reg;

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic       out_disc_reg;

    logic       has_words, load, final_word, accept;
    logic [7:0] w_byte;
    logic       w_last, w_disc;

    assign has_words = pend_emit_reg || (pend_fin_reg != FIN_NONE);
    assign load      = has_words && (!out_valid_reg || out_ready);
    assign in_ready  = !has_words || (load && final_word);
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        w_byte     = 8'h00;
        w_last     = 1'b0;
        w_disc     = 1'b0;
        final_word = 1'b0;
        if (pend_emit_reg)
        begin
            w_byte     = pend_data_reg;
            final_word = (pend_fin_reg == FIN_NONE);
        end
        else
        begin
            case (pend_fin_reg)
                FIN_DISCARD:
                begin
                    w_last     = 1'b1;
                    w_disc     = 1'b1;
                    final_word = 1'b1;
                end
                FIN_ANSWER:
                begin
                    w_byte     = ans_byte(ans_idx_reg, ip);
                    w_last     = (ans_idx_reg == 4'(ANS_LEN - 1));
                    final_word = w_last;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_emit_reg <= 1'b0;
            pend_fin_reg  <= FIN_NONE;
            ans_idx_reg   <= 4'd0;
        end
        else if (accept)
        begin
            pend_emit_reg <= res.emit;
            pend_fin_reg  <= res.fin;
            ans_idx_reg   <= 4'd0;
        end
        else if (load)
        begin
            if (pend_emit_reg)
                pend_emit_reg <= 1'b0;
            else if (pend_fin_reg == FIN_ANSWER)
            begin
                ans_idx_reg <= ans_idx_reg + 4'd1;
                if (final_word)
                    pend_fin_reg <= FIN_NONE;
            end
            else
                pend_fin_reg <= FIN_NONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            pend_data_reg <= res.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= w_byte;
            out_last_reg <= w_last;
            out_disc_reg <= w_disc;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign out_disc  = out_disc_reg;

endmodule

/* src/captive_dns_responder_unit.sv */
// ----------------------------------------------------------------------------
// captive_dns_responder_unit
// Rewrites a DNS query stream into a captive-portal answer stream.
// ----------------------------------------------------------------------------
// The query enters one byte per word on the s_ channel, s_tlast on its final
// byte. Response bytes leave on the m_ channel, m_tlast on the final word of
// each packet. The header is rewritten (ID kept, flags 8180, one question,
// one answer) and the first question is copied word for word through the
// pending stage and output register; bytes after the question and bytes
// past MAX_PACKET produce no word. The final query byte is followed by a
// 16-word answer record (name pointer, type A, class IN, TTL 60, length 4,
// address from cfg_wdata). While that record plays out through the single
// answer counter s_tready is low; every other byte is taken one per cycle
// while m_tready is high. A query whose question is incomplete at its end
// gets one word instead, with m_tlast and m_tuser (discard) set, data zero.
// cfg_we loads the answer address, first octet in the top byte; write it
// only while no packet is in flight.
// Reset clears the parser to the header, empties the output register and
// sets the address to 0.0.0.0. When m_tready is low the output word holds and
// input is taken until the one pending stage behind the output is full.
// ----------------------------------------------------------------------------
module captive_dns_responder_unit
    import dnsr_pkg::*;
#(
    parameter int MAX_PACKET = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // data_byte
    input  logic        s_tlast,    // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // out_byte
    output logic        m_tlast,    // out_last
    output logic        m_tuser,    // discard
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);

    logic [31:0] ip_reg;
    parse_res_t  res;
    logic        in_accept;

    assign in_accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ip_reg <= 32'd0;
        else if (cfg_we)
            ip_reg <= cfg_wdata;
    end

    dnsr_parser #(
        .MAX_PACKET (MAX_PACKET)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .in_data   (s_tdata),
        .in_last   (s_tlast),
        .res       (res)
    );

    dnsr_emitter u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .res       (res),
        .ip        (ip_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_last  (m_tlast),
        .out_disc  (m_tuser)
    );

endmodule

/* src/dnsr_checker.sv */
// ----------------------------------------------------------------------------
// dnsr_checker
// Port-level checks of the captive DNS responder.
// ----------------------------------------------------------------------------
module dnsr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast,
    input logic        m_tuser,
    input logic        cfg_we,
    input logic [31:0] cfg_wdata
);

    logic [31:0] ip_shadow_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ip_shadow_reg <= 32'd0;
        else if (cfg_we)
            ip_shadow_reg <= cfg_wdata;
    end

    // stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("output word changed while stalled");

    // a presented word carries defined values
    a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !$isunknown({m_tdata, m_tlast, m_tuser}))
        else $error("output word has unknown bits");

    // discard only on an empty closing word
    a_discard_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata == 8'h00))
        else $error("discard word malformed");

    // answer record closes with the low octet of the address
    a_answer_ip: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast && !m_tuser |-> m_tdata == ip_shadow_reg[7:0])
        else $error("answer does not end with address low octet");

endmodule

bind captive_dns_responder_unit dnsr_checker u_dnsr_checker (.*);
